@@ rtl/wts_pkg.sv @@
// shared types, codes and sizes of the weighted table sampler
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

  // sizes of the map and the value store
  localparam int MAX_ENTRIES   = 16;
  localparam int VALUE_SLOTS   = 256;
  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 8;
  localparam int RUN_COUNT_W = 9;
  localparam int RUN_IDX_W   = 8;
  localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES);
  localparam int VALUE_AW    = $clog2(VALUE_SLOTS);
  localparam int CFG_W       = 5;
  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;

  // run index divider
  localparam int PROD_W = FRACTION_BITS + RUN_COUNT_W;
  localparam int DSR_W  = FRACTION_BITS + RUN_IDX_W - 1;
  localparam int STEP_W = $clog2(RUN_IDX_W);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(RUN_IDX_W - 1);
  localparam logic [RUN_COUNT_W-1:0] RUN_LIMIT = RUN_COUNT_W'(256);

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_ENTRY = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_SLOT  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE      = 2'd2;

  // register index (byte address bit 2)
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = CFG_W'(1);

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [SLOT_W-1:0]        slot;
    logic [FRACTION_BITS-1:0] weight;
    logic [SLOT_W-1:0]        run_base;
    logic [RUN_COUNT_W-1:0]   run_count;
    logic [VALUE_BITS-1:0]    data_value;
    logic [FRACTION_BITS-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  chosen_value;
    logic [ENTRY_IDX_W-1:0] chosen_entry;
    logic [RUN_IDX_W-1:0]   run_index;
    logic                   fell_through;
  } out_item_t;

  typedef enum logic [1:0] {
    K_ENTRY,
    K_SLOT,
    K_SAMPLE
  } kind_e;

  typedef struct packed {
    kind_e    kind;
    in_item_t data;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } queue_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WALK,
    B_SETUP,
    B_DIV,
    B_READ,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

@@ rtl/wts_ram.sv @@
// generic single write port, registered read port ram
`timescale 1ns / 1ps
`default_nettype none

module wts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/wts_front.sv @@
// input side: accepts transactions, classifies them and queues the useful ones
`timescale 1ns / 1ps
`default_nettype none

module wts_front import wts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output queue_t   queue_o,
  input  logic     pop_i
);

  q_item_t           q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              keep;
  kind_e             kind;
  logic              push;

  // drop unused ops and out-of-range writes here
  always_comb begin
    keep = 1'b0;
    kind = K_SAMPLE;
    unique case (in_item_i.op)
      OP_WRITE_ENTRY: begin
        kind = K_ENTRY;
        keep = ({1'b0, in_item_i.slot} < (SLOT_W + 1)'(MAX_ENTRIES));
      end
      OP_WRITE_SLOT: begin
        kind = K_SLOT;
        keep = ({1'b0, in_item_i.slot} < (SLOT_W + 1)'(VALUE_SLOTS));
      end
      OP_SAMPLE: begin
        kind = K_SAMPLE;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (count_q == QCNT_W'(QDEPTH));
  assign push       = in_valid_i & ~in_stall_o & keep;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{kind: kind, data: in_item_i};
    end
  end

  assign queue_o.valid = (count_q != '0);
  assign queue_o.item  = q_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/wts_back.sv @@
// execution side: map writes, value store writes and the sampling walk and divide
`timescale 1ns / 1ps
`default_nettype none

module wts_back import wts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] entry_count_i,
  input  queue_t           queue_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  // map entries, read only at the walk counter
  logic [FRACTION_BITS-1:0] ent_weight_q [MAX_ENTRIES];
  logic [RUN_COUNT_W-1:0]   ent_count_q  [MAX_ENTRIES];
  logic [SLOT_W-1:0]        ent_base_q   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]    ent_single_q [MAX_ENTRIES];

  back_state_e state_q, state_d;

  logic [ENTRY_IDX_W-1:0]   idx_q, idx_d;
  logic [ENTRY_IDX_W-1:0]   last_q, last_d;
  logic [ENTRY_IDX_W-1:0]   pick_q, pick_d;
  logic                     fell_q, fell_d;
  logic [FRACTION_BITS-1:0] rest_q, rest_d;
  logic [FRACTION_BITS-1:0] w_q, w_d;
  logic [RUN_COUNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOT_W-1:0]        base_q, base_d;
  logic [VALUE_BITS-1:0]    single_q, single_d;
  logic                     use_ram_q, use_ram_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [DSR_W-1:0]         dsr_q, dsr_d;
  logic [RUN_IDX_W-1:0]     quot_q, quot_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [RUN_IDX_W-1:0]     ridx_q, ridx_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_item_q, out_item_d;

  logic [ENTRY_IDX_W-1:0]   last_idx;
  logic [FRACTION_BITS-1:0] w_rd;
  logic [RUN_COUNT_W-1:0]   cnt_rd;
  logic                     walk_hit;
  logic                     walk_end;
  logic                     setup_div;
  logic                     div_ge;
  logic                     out_free;
  logic                     ent_we;
  logic                     ram_we;
  logic                     ram_re;
  logic [VALUE_AW-1:0]      ram_raddr;
  logic [VALUE_BITS-1:0]    ram_rdata;
  logic [ENTRY_IDX_W-1:0]   ent_widx;

  // entries in use: zero means one, above the map size means all
  always_comb begin
    if (entry_count_i == '0) begin
      last_idx = '0;
    end else if (entry_count_i > CFG_W'(MAX_ENTRIES)) begin
      last_idx = ENTRY_IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_idx = ENTRY_IDX_W'(entry_count_i - 1'b1);
    end
  end

  assign w_rd   = ent_weight_q[idx_q];
  assign cnt_rd = (ent_count_q[idx_q] > RUN_LIMIT) ? RUN_LIMIT : ent_count_q[idx_q];

  assign walk_hit  = (rest_q < w_rd);
  assign walk_end  = (idx_q == last_q);
  assign setup_div = (cnt_q != '0) && (rest_q < w_q);
  assign div_ge    = (prod_q >= PROD_W'(dsr_q));
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign ent_widx  = queue_i.item.data.slot[ENTRY_IDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (queue_i.valid && (queue_i.item.kind == K_SAMPLE)) begin
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        if (walk_hit || walk_end) begin
          state_d = B_SETUP;
        end
      end
      B_SETUP: begin
        if (cnt_q == '0) begin
          state_d = B_DONE;
        end else if (setup_div) begin
          state_d = B_DIV;
        end else begin
          state_d = B_READ;
        end
      end
      B_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // datapath and strobes
  always_comb begin
    pop_o     = 1'b0;
    ent_we    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = VALUE_AW'(base_q + ridx_q);
    idx_d     = idx_q;
    last_d    = last_q;
    pick_d    = pick_q;
    fell_d    = fell_q;
    rest_d    = rest_q;
    w_d       = w_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    single_d  = single_q;
    use_ram_d = use_ram_q;
    prod_d    = prod_q;
    dsr_d     = dsr_q;
    quot_d    = quot_q;
    step_d    = step_q;
    ridx_d    = ridx_q;
    out_item_d.chosen_value = use_ram_q ? ram_rdata : single_q;
    out_item_d.chosen_entry = pick_q;
    out_item_d.run_index    = ridx_q;
    out_item_d.fell_through = fell_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      B_IDLE: begin
        if (queue_i.valid) begin
          pop_o = 1'b1;
          unique case (queue_i.item.kind)
            K_ENTRY: ent_we = 1'b1;
            K_SLOT:  ram_we = 1'b1;
            K_SAMPLE: begin
              rest_d = queue_i.item.data.random_fraction;
              idx_d  = '0;
              last_d = last_idx;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      B_WALK: begin
        if (!walk_hit) begin
          rest_d = rest_q - w_rd;
        end
        if (walk_hit || walk_end) begin
          pick_d   = idx_q;
          fell_d   = ~walk_hit;
          w_d      = w_rd;
          cnt_d    = cnt_rd;
          base_d   = ent_base_q[idx_q];
          single_d = ent_single_q[idx_q];
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      B_SETUP: begin
        use_ram_d = (cnt_q != '0);
        if (cnt_q == '0) begin
          ridx_d = '0;
        end else if (!setup_div) begin
          // zero weight or leftover fraction at or beyond the weight saturates
          ridx_d = RUN_IDX_W'(cnt_q - 1'b1);
        end
        prod_d = PROD_W'(rest_q) * PROD_W'(cnt_q);
        dsr_d  = {w_q, {(RUN_IDX_W - 1){1'b0}}};
        quot_d = '0;
        step_d = '0;
      end
      B_DIV: begin
        if (div_ge) begin
          prod_d = prod_q - PROD_W'(dsr_q);
        end
        quot_d = {quot_q[RUN_IDX_W-2:0], div_ge};
        dsr_d  = dsr_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          ridx_d = quot_d;
        end
      end
      B_READ: begin
        ram_re = 1'b1;
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    last_q    <= last_d;
    pick_q    <= pick_d;
    fell_q    <= fell_d;
    rest_q    <= rest_d;
    w_q       <= w_d;
    cnt_q     <= cnt_d;
    base_q    <= base_d;
    single_q  <= single_d;
    use_ram_q <= use_ram_d;
    prod_q    <= prod_d;
    dsr_q     <= dsr_d;
    quot_q    <= quot_d;
    step_q    <= step_d;
    ridx_q    <= ridx_d;
    if ((state_q == B_DONE) && out_free) begin
      out_item_q <= out_item_d;
    end
    if (ent_we) begin
      ent_weight_q[ent_widx] <= queue_i.item.data.weight;
      ent_count_q[ent_widx]  <= queue_i.item.data.run_count;
      ent_base_q[ent_widx]   <= queue_i.item.data.run_base;
      ent_single_q[ent_widx] <= queue_i.item.data.data_value;
    end
  end

  wts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VALUE_SLOTS)
  ) u_value_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (queue_i.item.data.slot[VALUE_AW-1:0]),
    .wdata_i (queue_i.item.data.data_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WALK) |-> (idx_q <= last_q))
    else $error("walk index past last entry in use");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> ({1'b0, prod_q} < {2'b0, dsr_q, 1'b0}))
    else $error("divider remainder out of range");

  a_ridx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == B_DONE) && (cnt_q != '0)) |-> ({1'b0, ridx_q} < cnt_q))
    else $error("run index not below run count");

  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == B_DONE) && fell_q) |-> (pick_q == last_q))
    else $error("fall-through did not take last entry");
`endif

endmodule

`default_nettype wire

@@ rtl/weighted_table_sampler.sv @@
// top level of the weighted table sampler: config register and front/back halves
`timescale 1ns / 1ps
`default_nettype none

// Roulette wheel sampler over a map of up to 16 entries. Write-entry and
// write-slot transactions load the map and the 256-deep value store; a sample
// transaction walks the entries in order, subtracting weights from its random
// fraction, and returns one result (value, entry, run index, fall-through flag).
// Writes and dropped ops give no result. The front queues up to two transactions
// so the input keeps moving while the back works. Steps per transaction at the
// back: a write is popped and done; a sample is popped, walks the entries one
// per cycle until entry k is picked (up to the number of entries in use), then
// takes a setup step, a bit-serial divide for the run index when the entry has a
// run and the leftover is below its weight, a value store read when the entry
// has a run, and an output step, which waits while the output register is full
// and stalled.
// The result sits in an output register, so the back starts the next transaction
// while it waits. No clearing pass: map and store are undefined until written.
// entry_count lives at byte address 0 and should be written only while idle.
module weighted_table_sampler import wts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [CFG_W-1:0] entry_count_q, entry_count_d;
  logic             cfg_write;
  logic             reg_hit;
  queue_t           queue;
  logic             pop;

  // register index is the byte address over four
  assign reg_hit   = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_comb begin
    entry_count_d = entry_count_q;
    if (cfg_write && reg_hit) begin
      entry_count_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RESET;
    end else begin
      entry_count_q <= entry_count_d;
    end
  end

  // reads of addresses past the register list return zero
  assign prdata = reg_hit ? APB_DW'(entry_count_q) : '0;

  // front: accept, classify, queue
  wts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .queue_o    (queue),
    .pop_i      (pop)
  );

  // back: map/store writes, walk, divide, value lookup, output register
  wts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .queue_i       (queue),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

`default_nettype wire

@@ dv/weighted_table_sampler_test.sv @@
// self-checking testbench for the weighted table sampler
`timescale 1ns / 1ps

module weighted_table_sampler_test;
  import wts_pkg::*;

  // op code the block drops without a result
  localparam logic [OP_W-1:0]    OP_UNUSED        = 2'd3;
  // entry_count is register 0, byte address 0
  localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = PADDR_W'(0);
  localparam int MAX_GAP       = 14;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES   = 400;
  // idle time before a register write or the end; covers two queued
  // transactions plus a full sixteen-entry walk with the divider
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 190;
  localparam int MAX_REPORTS   = 10;
  localparam out_item_t NO_DRAW = '0;

  // one row of the directed table: the transaction, and where the result can
  // be read off directly, the result typed in
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t draw;
  } table_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // shadow copy of the map, the value store and the register
  logic [FRACTION_BITS-1:0] map_weight    [MAX_ENTRIES];
  logic [RUN_COUNT_W-1:0]   map_run_count [MAX_ENTRIES];
  logic [SLOT_W-1:0]        map_run_base  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]    map_single    [MAX_ENTRIES];
  bit                       map_written   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]    store_value   [VALUE_SLOTS];
  bit                       store_written [VALUE_SLOTS];
  logic [CFG_W-1:0]         entries_reg;

  out_item_t  draws_pending [$];
  table_row_t directed_rows [$];
  int         fail_count   = 0;
  int         report_count = 0;
  int         item_total   = 0;
  // quiet stretches: no gaps on that side until the flag flips again
  bit         tx_quiet     = 1'b0;
  bit         rx_quiet     = 1'b0;
  bit         hold_req     = 1'b0;

  weighted_table_sampler u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // roulette walk over the shadow map; also reports the first entry or value
  // slot the walk would read before it was ever written (-1 when none)
  function automatic out_item_t walk_map(input logic [FRACTION_BITS-1:0] frac,
                                         output int need_entry, output int need_slot);
    out_item_t   res;
    int unsigned n, rest, pick, cnt, w, idx, addr, i;
    bit          fell, hit;
    res = '0;
    // out-of-range register values clamp to 1..MAX_ENTRIES
    n = (entries_reg == 0) ? 1 : (entries_reg > MAX_ENTRIES) ? MAX_ENTRIES : entries_reg;
    rest = frac;
    pick = n - 1;
    fell = 1'b1;
    hit = 1'b0;
    idx = 0;
    need_entry = -1;
    need_slot = -1;
    for (i = 0; i < n && !hit; i++) begin
      if (!map_written[i] && need_entry < 0) need_entry = i;
      if (rest < map_weight[i]) begin
        pick = i;
        fell = 1'b0;
        hit = 1'b1;
      end else begin
        rest -= map_weight[i];
      end
    end
    // fall-through keeps the leftover fraction for the last entry in use
    cnt = (map_run_count[pick] > RUN_LIMIT) ? RUN_LIMIT : map_run_count[pick];
    w = map_weight[pick];
    if (cnt == 0) begin
      res.chosen_value = map_single[pick];
    end else begin
      // zero weight, or leftover past the weight, saturates to the last element
      if (w == 0) begin
        idx = cnt - 1;
      end else begin
        idx = rest * cnt / w;
        if (idx > cnt - 1) idx = cnt - 1;
      end
      // runs wrap around the end of the value store
      addr = (map_run_base[pick] + idx) % VALUE_SLOTS;
      if (!store_written[addr]) need_slot = addr;
      res.chosen_value = store_value[addr];
    end
    res.chosen_entry = pick[ENTRY_IDX_W-1:0];
    res.run_index = idx[RUN_IDX_W-1:0];
    res.fell_through = fell;
    return res;
  endfunction

  // update the shadow state for one accepted transaction; 1 when it gives a draw
  function automatic bit apply_item(input in_item_t it, output out_item_t res);
    int ne, ns;
    res = '0;
    case (it.op)
      OP_WRITE_ENTRY: begin
        if (it.slot < MAX_ENTRIES) begin
          map_weight[it.slot] = it.weight;
          map_run_base[it.slot] = it.run_base;
          map_run_count[it.slot] = it.run_count;
          map_single[it.slot] = it.data_value;
          map_written[it.slot] = 1'b1;
        end
      end
      OP_WRITE_SLOT: begin
        store_value[it.slot] = it.data_value;
        store_written[it.slot] = 1'b1;
      end
      OP_SAMPLE: begin
        res = walk_map(it.random_fraction, ne, ns);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op = $urandom;
    it.slot = $urandom;
    it.weight = $urandom;
    it.run_base = $urandom;
    it.run_count = $urandom;
    it.data_value = $urandom;
    it.random_fraction = $urandom;
    return it;
  endfunction

  function automatic in_item_t entry_item(input int unsigned idx, input logic [15:0] w);
    in_item_t    it;
    int unsigned sel;
    it = random_fields();
    it.op = OP_WRITE_ENTRY;
    it.slot = idx;
    it.weight = w;
    // mostly single values and short runs, some long and over-long runs
    sel = $urandom_range(0, 9);
    if (sel < 3) it.run_count = '0;
    else if (sel < 8) it.run_count = $urandom_range(1, 8);
    else if (sel == 8) it.run_count = $urandom_range(9, 256);
    else it.run_count = $urandom_range(257, 511);
    return it;
  endfunction

  function automatic in_item_t slot_item(input int unsigned addr);
    in_item_t it;
    it = random_fields();
    it.op = OP_WRITE_SLOT;
    it.slot = addr;
    return it;
  endfunction

  // offer one transaction after a random gap, called and returning at a falling edge
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_draw);
    int        gap;
    out_item_t draw;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (apply_item(it, draw)) draws_pending.push_back(typed ? typed_draw : draw);
    // dropped transactions do not count toward the random budget
    if (!(it.op == OP_UNUSED || (it.op == OP_WRITE_ENTRY && it.slot >= MAX_ENTRIES)))
      item_total++;
    @(negedge clk);
  endtask

  // a sample only goes out once every entry and slot it reads has been loaded;
  // missing ones are written first
  task automatic draw_sample(input logic [FRACTION_BITS-1:0] frac);
    int        ne, ns;
    out_item_t probe;
    in_item_t  it;
    bit        sent;
    sent = 1'b0;
    while (!sent) begin
      probe = walk_map(frac, ne, ns);
      if (ne >= 0) begin
        send_item(entry_item(ne, $urandom), 1'b0, NO_DRAW);
      end else if (ns >= 0) begin
        send_item(slot_item(ns), 1'b0, NO_DRAW);
      end else begin
        it = random_fields();
        it.op = OP_SAMPLE;
        it.random_fraction = frac;
        send_item(it, 1'b0, NO_DRAW);
        sent = 1'b1;
      end
    end
  endtask

  // load entries 0..n-1 as a full wheel, a short wheel or arbitrary weights
  task automatic build_map(input int unsigned n);
    int unsigned remain, w, i, style;
    style = $urandom_range(0, 3);
    remain = (style == 2) ? $urandom_range(0, 65535) : 65536;
    for (i = 0; i < n; i++) begin
      if (style == 3) begin
        w = $urandom_range(0, 65535);
      end else if (i == n - 1) begin
        w = (remain > 65535) ? 65535 : remain;
      end else if ($urandom_range(0, 5) == 0) begin
        w = 0;
      end else begin
        w = $urandom_range(0, 2 * remain / (n - i));
        if (w > remain) w = remain;
        if (w > 65535) w = 65535;
      end
      if (style != 3) remain -= w;
      send_item(entry_item(i, w), 1'b0, NO_DRAW);
    end
  endtask

  // drop valid and wait until every draw is back and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (draws_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup and access phase on the config port, only while the block is idle
  task automatic set_entry_count(input int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ENTRY_COUNT_ADDR;
    pwdata = APB_DW'(value[CFG_W-1:0]);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    entries_reg = value[CFG_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // stimulus: reset, directed table, then random phases at several entry counts
  initial begin
    int                       entry_settings [8];
    int                       setting, n_use, phase_end, sel, p;
    logic [FRACTION_BITS-1:0] frac;
    in_item_t                 it;
    entry_settings = '{16, 1, 0, 31, 5, 16, -1, 8};
    entries_reg = ENTRY_COUNT_RESET;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      map_weight[i] = '0;
      map_run_count[i] = '0;
      map_run_base[i] = '0;
      map_single[i] = '0;
      map_written[i] = 1'b0;
    end
    for (int i = 0; i < VALUE_SLOTS; i++) begin
      store_value[i] = '0;
      store_written[i] = 1'b0;
    end

    // directed table, run at the reset entry count of one
    // single value, hit on fraction zero and fall-through on all ones
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd0, 16'hFFFF, 8'h00, 9'd0, 32'hFFFF_FFFF,
                             16'h0000, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h0000,
                             1'b1, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b0});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'hFFFF,
                             1'b1, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b1});
    // store extremes, and the slot that a wrapped 256-long run lands on
    directed_rows.push_back({OP_WRITE_SLOT, 8'h00, 16'h0, 8'h0, 9'd0, 32'h0000_0000,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_WRITE_SLOT, 8'hFF, 16'h0, 8'h0, 9'd0, 32'h1234_5678,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_WRITE_SLOT, 8'hFE, 16'h0, 8'h0, 9'd0, 32'hDEAD_BEEF,
                             16'h0, 1'b0, NO_DRAW});
    // zero weight with a full run: index saturates to 255, base 255 wraps to 254
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd0, 16'h0000, 8'hFF, 9'd256, 32'h0,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h0000,
                             1'b1, 32'hDEAD_BEEF, 4'd0, 8'hFF, 1'b1});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'hFFFF,
                             1'b1, 32'hDEAD_BEEF, 4'd0, 8'hFF, 1'b1});
    // unused op and out-of-range entry writes must leave the map alone
    directed_rows.push_back({OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF, 32'hFFFF_FFFF,
                             16'hFFFF, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_WRITE_ENTRY, 8'hFF, 16'h1234, 8'h01, 9'd0, 32'h0BAD_0BAD,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd16, 16'h4321, 8'h02, 9'd0, 32'h0BAD_0BAD,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h0000,
                             1'b1, 32'hDEAD_BEEF, 4'd0, 8'hFF, 1'b1});
    // over-long run clamps to 256, hit near the top and fall-through past it
    directed_rows.push_back({OP_WRITE_SLOT, 8'h0F, 16'h0, 8'h0, 9'd0, 32'hCAFE_F00D,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd0, 16'h8000, 8'h10, 9'h1FF, 32'h0,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h7FFF,
                             1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'hFFFF,
                             1'b0, NO_DRAW});
    // smallest nonzero weight, one-element run
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd0, 16'h0001, 8'h00, 9'd1, 32'h0,
                             16'h0, 1'b0, NO_DRAW});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h0000,
                             1'b1, 32'h0, 4'd0, 8'd0, 1'b0});
    directed_rows.push_back({OP_SAMPLE, 8'h00, 16'h0000, 8'h00, 9'd0, 32'h0, 16'h0001,
                             1'b1, 32'h0, 4'd0, 8'd0, 1'b1});
    // last entry index
    directed_rows.push_back({OP_WRITE_ENTRY, 8'd15, 16'hFFFF, 8'h80, 9'd2, 32'h55AA_55AA,
                             16'h0, 1'b0, NO_DRAW});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].draw);

    // random phases; the register changes only between them
    for (p = 0; p < 8; p++) begin
      setting = (entry_settings[p] < 0) ? $urandom_range(2, 15) : entry_settings[p];
      settle();
      set_entry_count(setting);
      n_use = (setting == 0) ? 1 : (setting > MAX_ENTRIES) ? MAX_ENTRIES : setting;
      build_map(n_use);
      // first phase: receiver stops for a long stretch while samples keep coming
      if (p == 0) begin
        hold_req = 1'b1;
        tx_quiet = 1'b1;
      end
      phase_end = item_total + PHASE_ITEMS;
      while (item_total < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          if ($urandom_range(0, 9) == 0) frac = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          else frac = $urandom;
          draw_sample(frac);
        end else if (sel < 85) begin
          send_item(slot_item($urandom_range(0, VALUE_SLOTS - 1)), 1'b0, NO_DRAW);
        end else if (sel < 93) begin
          // rewrite of a live entry breaks up the wheel
          send_item(entry_item($urandom_range(0, MAX_ENTRIES - 1), $urandom), 1'b0, NO_DRAW);
        end else begin
          it = random_fields();
          it.op = $urandom_range(0, 1) ? OP_UNUSED : OP_WRITE_ENTRY;
          if (it.op == OP_WRITE_ENTRY) it.slot = $urandom_range(MAX_ENTRIES, 255);
          send_item(it, 1'b0, NO_DRAW);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random stall per transaction, quiet stretches, one long hold
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      n = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      out_stall = (n != 0);
      repeat (n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
    end
  end

  // compare every accepted draw with the oldest expectation
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (draws_pending.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("[%0t] draw with nothing pending: value %h entry %0d index %0d fell %b",
                     $realtime, out_item.chosen_value, out_item.chosen_entry,
                     out_item.run_index, out_item.fell_through);
          end
        end else begin
          want = draws_pending.pop_front();
          if (out_item.chosen_value !== want.chosen_value ||
              out_item.chosen_entry !== want.chosen_entry ||
              out_item.run_index !== want.run_index ||
              out_item.fell_through !== want.fell_through) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("[%0t] draw differs: expected value %h entry %0d index %0d fell %b",
                       $realtime, want.chosen_value, want.chosen_entry, want.run_index,
                       want.fell_through);
              $display("            got value %h entry %0d index %0d fell %b",
                       out_item.chosen_value, out_item.chosen_entry, out_item.run_index,
                       out_item.fell_through);
            end
          end
        end
      end
    end
  end

  // hard limit on the run time
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wts_pkg.sv
rtl/wts_ram.sv
rtl/wts_front.sv
rtl/wts_back.sv
rtl/weighted_table_sampler.sv
dv/weighted_table_sampler_test.sv
